@@ rtl/core/tap_gesture_and_fall_alarm_qualifier_assert.svh @@
// ----------------------------------------------------------------------------
// Tap gesture and fall alarm qualifier: assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef TAP_GESTURE_AND_FALL_ALARM_QUALIFIER_ASSERT_SVH
`define TAP_GESTURE_AND_FALL_ALARM_QUALIFIER_ASSERT_SVH

// same-cycle implication
`define TGFA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TGFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/tgfa_pkg.sv @@
// ----------------------------------------------------------------------------
// Tap gesture and fall alarm qualifier: package
// Shared widths, codes, register defaults, types and window compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tgfa_pkg;

	localparam int TIME_WIDTH     = 40;
	localparam int WIN_WIDTH      = 16;
	localparam int LIMIT_WIDTH    = 4;
	localparam int REPORT_WIDTH   = 5;
	localparam int CMD_WIDTH      = 2;
	localparam int CFG_IDX_WIDTH  = 2;
	localparam int CFG_DATA_WIDTH = 16;

	localparam logic [WIN_WIDTH-1:0]   PAIR_WINDOW_RST    = 16'd2000;
	localparam logic [WIN_WIDTH-1:0]   CONFIRM_WINDOW_RST = 16'd5000;
	localparam logic [WIN_WIDTH-1:0]   FALL_WINDOW_RST    = 16'd1000;
	localparam logic [LIMIT_WIDTH-1:0] FALL_LIMIT_RST     = 4'd4;

	typedef enum logic [CMD_WIDTH-1:0] {
		CMD_DOUBLE_TAP = 2'd0,
		CMD_FREE_FALL  = 2'd1,
		CMD_PEER_CLEAR = 2'd2,
		CMD_IGNORED    = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		REG_PAIR_WINDOW    = 2'd0,
		REG_CONFIRM_WINDOW = 2'd1,
		REG_FALL_WINDOW    = 2'd2,
		REG_FALL_LIMIT     = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [WIN_WIDTH-1:0]   pair_window;
		logic [WIN_WIDTH-1:0]   confirm_window;
		logic [WIN_WIDTH-1:0]   fall_window;
		logic [LIMIT_WIDTH-1:0] fall_limit;
	} cfg_t;

	typedef struct packed {
		logic [CMD_WIDTH-1:0]  command;
		logic [TIME_WIDTH-1:0] now_ms;
	} item_t;

	typedef struct packed {
		logic                    alarm_active;
		logic                    alarm_started;
		logic                    alarm_stopped;
		logic                    find_phone;
		logic                    feedback_pulse;
		logic [REPORT_WIDTH-1:0] fall_reports;
	} result_t;

	// true when now lies more than win after then_ms; a time that runs
	// backwards counts as no time gone by
	function automatic logic past_window(
		input logic [TIME_WIDTH-1:0] now,
		input logic [TIME_WIDTH-1:0] then_ms,
		input logic [WIN_WIDTH-1:0]  win
	);
		logic [TIME_WIDTH-1:0] gap;
		gap = now - then_ms;
		return (now >= then_ms) && (gap > {{(TIME_WIDTH-WIN_WIDTH){1'b0}}, win});
	endfunction

endpackage

@@ rtl/core/tgfa_in_if.sv @@
// ----------------------------------------------------------------------------
// Tap gesture and fall alarm qualifier: event channel
// Valid/ready channel that carries one timestamped sensor event.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tgfa_in_if import tgfa_pkg::*;;

	logic                  valid;
	logic                  ready;
	logic [CMD_WIDTH-1:0]  command;
	logic [TIME_WIDTH-1:0] now_ms;

	modport source (output valid, output command, output now_ms, input ready);
	modport sink   (input valid, input command, input now_ms, output ready);

endinterface

@@ rtl/core/tgfa_out_if.sv @@
// ----------------------------------------------------------------------------
// Tap gesture and fall alarm qualifier: result channel
// Valid/ready channel that carries one qualified result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tgfa_out_if import tgfa_pkg::*;;

	logic                    valid;
	logic                    ready;
	logic                    alarm_active;
	logic                    alarm_started;
	logic                    alarm_stopped;
	logic                    find_phone;
	logic                    feedback_pulse;
	logic [REPORT_WIDTH-1:0] fall_reports;

	modport source (
		output valid, output alarm_active, output alarm_started, output alarm_stopped,
		output find_phone, output feedback_pulse, output fall_reports, input ready
	);
	modport sink (
		input valid, input alarm_active, input alarm_started, input alarm_stopped,
		input find_phone, input feedback_pulse, input fall_reports, output ready
	);

endinterface

@@ rtl/core/tgfa_qual.sv @@
// ----------------------------------------------------------------------------
// Tap gesture and fall alarm qualifier: event evaluator
// Holds gesture, arming and fall-count state; evaluates one event per cycle in which en is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgfa_qual import tgfa_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	logic [TIME_WIDTH-1:0]   fall_start_q;
	logic [REPORT_WIDTH-1:0] fall_tally_q;
	logic [TIME_WIDTH-1:0]   first_tap_time_q;
	logic                    first_tap_pending_q;
	logic [TIME_WIDTH-1:0]   armed_time_q;
	logic                    awaiting_q;
	logic                    will_confirm_q;
	logic                    alarm_on_q;

	logic [TIME_WIDTH-1:0]   fall_start_d;
	logic [REPORT_WIDTH-1:0] fall_tally_d;
	logic [TIME_WIDTH-1:0]   first_tap_time_d;
	logic                    first_tap_pending_d;
	logic [TIME_WIDTH-1:0]   armed_time_d;
	logic                    awaiting_d;
	logic                    will_confirm_d;
	logic                    alarm_on_d;

	logic                    pair_expired;
	logic                    confirm_expired;
	logic                    fall_expired;
	logic [REPORT_WIDTH-1:0] tally_next;

	assign pair_expired    = past_window(item.now_ms, first_tap_time_q, cfg.pair_window);
	assign confirm_expired = past_window(item.now_ms, armed_time_q, cfg.confirm_window);
	assign fall_expired    = past_window(item.now_ms, fall_start_q, cfg.fall_window);

	assign tally_next = (fall_tally_q == '0 || fall_expired) ?
		REPORT_WIDTH'(1) : REPORT_WIDTH'(fall_tally_q + REPORT_WIDTH'(1));

	always_comb begin
		fall_start_d        = fall_start_q;
		fall_tally_d        = fall_tally_q;
		first_tap_time_d    = first_tap_time_q;
		first_tap_pending_d = first_tap_pending_q;
		armed_time_d        = armed_time_q;
		awaiting_d          = awaiting_q;
		will_confirm_d      = will_confirm_q;
		alarm_on_d          = alarm_on_q;
		res                 = '0;

		case (item.command)
			CMD_DOUBLE_TAP: begin
				if (!first_tap_pending_q || pair_expired) begin
					first_tap_time_d    = item.now_ms;
					first_tap_pending_d = 1'b1;
					will_confirm_d      = awaiting_q && !confirm_expired;
				end else begin
					first_tap_pending_d = 1'b0;
					if (alarm_on_q) begin
						will_confirm_d    = 1'b0;
						alarm_on_d        = 1'b0;
						res.alarm_stopped = 1'b1;
					end else if (will_confirm_q) begin
						awaiting_d     = 1'b0;
						will_confirm_d = 1'b0;
						res.find_phone = 1'b1;
					end else begin
						armed_time_d       = item.now_ms;
						awaiting_d         = 1'b1;
						res.feedback_pulse = 1'b1;
					end
				end
			end
			CMD_FREE_FALL: begin
				if (tally_next == REPORT_WIDTH'(1)) begin
					fall_start_d = item.now_ms;
				end
				fall_tally_d     = tally_next;
				res.fall_reports = tally_next;
				if (tally_next > {1'b0, cfg.fall_limit}) begin
					fall_tally_d = '0;
					if (!alarm_on_q) begin
						alarm_on_d        = 1'b1;
						res.alarm_started = 1'b1;
					end
				end
			end
			CMD_PEER_CLEAR: begin
				if (alarm_on_q) begin
					alarm_on_d        = 1'b0;
					res.alarm_stopped = 1'b1;
				end
			end
			default: begin
			end
		endcase

		res.alarm_active = alarm_on_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fall_tally_q        <= '0;
			first_tap_pending_q <= 1'b0;
			awaiting_q          <= 1'b0;
			will_confirm_q      <= 1'b0;
			alarm_on_q          <= 1'b0;
		end else if (en) begin
			fall_tally_q        <= fall_tally_d;
			first_tap_pending_q <= first_tap_pending_d;
			awaiting_q          <= awaiting_d;
			will_confirm_q      <= will_confirm_d;
			alarm_on_q          <= alarm_on_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fall_start_q     <= fall_start_d;
			first_tap_time_q <= first_tap_time_d;
			armed_time_q     <= armed_time_d;
		end
	end

endmodule

@@ rtl/core/tap_gesture_and_fall_alarm_qualifier.sv @@
// ----------------------------------------------------------------------------
// Tap gesture and fall alarm qualifier: top level
// Qualifies double-tap gestures and free-fall bursts into alarm and
// find-phone requests, one result per sensor event.
// ----------------------------------------------------------------------------
// Each request taken yields exactly one result: an input register, then a
// combinational evaluation in which the event is compared against the
// registered tap, arming and fall-window times and the state is updated,
// then the result register. The sustained rate of one event per cycle is set
// by that evaluation, whose state feeds back to the next event, while the
// input is not stalled. A held result stalls the input only once the input
// register is also full. The user must write window registers through the
// cfg port only while no request is in flight; the block does not check it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tap_gesture_and_fall_alarm_qualifier import tgfa_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	tgfa_in_if.sink                   sensor,
	tgfa_out_if.source                result,
	input  logic                      cfg_wen,
	input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata
);

	cfg_t    cfg_q;
	logic    run_q;
	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t res_s2;
	result_t res_eval;
	logic    advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pair_window    <= PAIR_WINDOW_RST;
			cfg_q.confirm_window <= CONFIRM_WINDOW_RST;
			cfg_q.fall_window    <= FALL_WINDOW_RST;
			cfg_q.fall_limit     <= FALL_LIMIT_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_PAIR_WINDOW:    cfg_q.pair_window    <= cfg_wdata[WIN_WIDTH-1:0];
				REG_CONFIRM_WINDOW: cfg_q.confirm_window <= cfg_wdata[WIN_WIDTH-1:0];
				REG_FALL_WINDOW:    cfg_q.fall_window    <= cfg_wdata[WIN_WIDTH-1:0];
				REG_FALL_LIMIT:     cfg_q.fall_limit     <= cfg_wdata[LIMIT_WIDTH-1:0];
				default: begin
				end
			endcase
		end
	end

	assign advance      = valid_s1 && (!valid_s2 || result.ready);
	assign sensor.ready = run_q && (!valid_s1 || advance);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			run_q <= 1'b1;
			if (sensor.ready) begin
				valid_s1 <= sensor.valid;
			end
			if (!valid_s2 || result.ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sensor.valid && sensor.ready) begin
			item_s1.command <= sensor.command;
			item_s1.now_ms  <= sensor.now_ms;
		end
		if (advance) begin
			res_s2 <= res_eval;
		end
	end

	tgfa_qual u_qual (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res_eval)
	);

	assign result.valid          = valid_s2;
	assign result.alarm_active   = res_s2.alarm_active;
	assign result.alarm_started  = res_s2.alarm_started;
	assign result.alarm_stopped  = res_s2.alarm_stopped;
	assign result.find_phone     = res_s2.find_phone;
	assign result.feedback_pulse = res_s2.feedback_pulse;
	assign result.fall_reports   = res_s2.fall_reports;

endmodule

@@ rtl/core/tgfa_checker.sv @@
// ----------------------------------------------------------------------------
// Tap gesture and fall alarm qualifier: port checker
// Watches the top-level ports for latency, hold and result consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tap_gesture_and_fall_alarm_qualifier_assert.svh"

module tgfa_checker import tgfa_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic                    alarm_active,
	input logic                    alarm_started,
	input logic                    alarm_stopped,
	input logic                    find_phone,
	input logic                    feedback_pulse,
	input logic [REPORT_WIDTH-1:0] fall_reports
);

	logic [REPORT_WIDTH+4:0] payload;

	assign payload = {alarm_active, alarm_started, alarm_stopped, find_phone,
		feedback_pulse, fall_reports};

	`TGFA_ASSERT_NOW(a_result_follows_request, clk, arst_n, $rose(out_valid), $past(in_valid && in_ready, 2), "result appeared without a request two cycles earlier")
	`TGFA_ASSERT_NEXT(a_stall_holds, clk, arst_n, out_valid && !out_ready, out_valid && $stable(payload), "stalled result changed")
	`TGFA_ASSERT_NOW(a_start_consistent, clk, arst_n, out_valid && alarm_started, alarm_active && !alarm_stopped && fall_reports != '0, "alarm start without active free-fall alarm")
	`TGFA_ASSERT_NOW(a_single_action, clk, arst_n, out_valid, fall_reports <= 5'd16 && !(find_phone && feedback_pulse), "fall count out of range or gesture both armed and confirmed")

endmodule

bind tap_gesture_and_fall_alarm_qualifier tgfa_checker u_tgfa_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (sensor.valid),
	.in_ready       (sensor.ready),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.alarm_active   (result.alarm_active),
	.alarm_started  (result.alarm_started),
	.alarm_stopped  (result.alarm_stopped),
	.find_phone     (result.find_phone),
	.feedback_pulse (result.feedback_pulse),
	.fall_reports   (result.fall_reports)
);

@@ test/tgfa_qualifier_checker.sv @@
// ----------------------------------------------------------------------------
// Tap gesture and fall alarm qualifier: result checker
// Watches the event, result and register ports, works out each event's
// outcome from its own copy of the windows and the gesture and fall state,
// and compares every returned result field by field, oldest first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgfa_qualifier_checker import tgfa_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	tgfa_in_if                        sensor,
	tgfa_out_if                       result,
	input  logic                      cfg_wen,
	input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata,
	output int                        fault_count,
	output int                        outcomes_owed
);

	logic [WIN_WIDTH-1:0]    pair_win;
	logic [WIN_WIDTH-1:0]    confirm_win;
	logic [WIN_WIDTH-1:0]    fall_win;
	logic [LIMIT_WIDTH-1:0]  fall_limit;
	logic [TIME_WIDTH-1:0]   fall_start;
	logic [TIME_WIDTH-1:0]   tap_time;
	logic [TIME_WIDTH-1:0]   arm_time;
	logic [REPORT_WIDTH-1:0] fall_count;
	logic                    tap_open;
	logic                    armed;
	logic                    will_confirm;
	logic                    alarm_on;
	result_t                 owed_outcomes[$];
	int                      results_taken;

	// a stamp earlier than the stored one counts as no time gone by
	function automatic logic beyond(
		input logic [TIME_WIDTH-1:0] now,
		input logic [TIME_WIDTH-1:0] since_ms,
		input logic [WIN_WIDTH-1:0]  win
	);
		logic [TIME_WIDTH-1:0] gone;
		gone = (now >= since_ms) ? now - since_ms : '0;
		return gone > TIME_WIDTH'(win);
	endfunction

	function automatic result_t judge_event(input cmd_t cmd, input logic [TIME_WIDTH-1:0] now);
		result_t r;
		r = '0;
		case (cmd)
			CMD_DOUBLE_TAP: begin
				if (!tap_open || beyond(now, tap_time, pair_win)) begin
					tap_time     = now;
					tap_open     = 1'b1;
					will_confirm = armed && !beyond(now, arm_time, confirm_win);
				end else begin
					tap_open = 1'b0;
					if (alarm_on) begin
						will_confirm    = 1'b0;
						alarm_on        = 1'b0;
						r.alarm_stopped = 1'b1;
					end else if (will_confirm) begin
						armed        = 1'b0;
						will_confirm = 1'b0;
						r.find_phone = 1'b1;
					end else begin
						arm_time         = now;
						armed            = 1'b1;
						r.feedback_pulse = 1'b1;
					end
				end
			end
			CMD_FREE_FALL: begin
				if (fall_count == '0 || beyond(now, fall_start, fall_win)) begin
					fall_start = now;
					fall_count = 5'd1;
				end else begin
					fall_count = fall_count + 5'd1;
				end
				r.fall_reports = fall_count;
				if (fall_count > REPORT_WIDTH'(fall_limit)) begin
					fall_count = '0;
					if (!alarm_on) begin
						alarm_on        = 1'b1;
						r.alarm_started = 1'b1;
					end
				end
			end
			CMD_PEER_CLEAR: begin
				if (alarm_on) begin
					alarm_on        = 1'b0;
					r.alarm_stopped = 1'b1;
				end
			end
			default: ;
		endcase
		r.alarm_active = alarm_on;
		return r;
	endfunction

	function automatic string describe(input result_t r);
		return $sformatf("active=%b started=%b stopped=%b find=%b pulse=%b reports=%0d",
			r.alarm_active, r.alarm_started, r.alarm_stopped, r.find_phone,
			r.feedback_pulse, r.fall_reports);
	endfunction

	// inputs only move at the rising edge, so the falling edge sees what the next one takes
	always @(negedge clk or negedge arst_n) begin : monitor
		result_t want;
		result_t got;
		string   wrong;
		if (!arst_n) begin
			pair_win      = PAIR_WINDOW_RST;
			confirm_win   = CONFIRM_WINDOW_RST;
			fall_win      = FALL_WINDOW_RST;
			fall_limit    = FALL_LIMIT_RST;
			fall_start    = '0;
			tap_time      = '0;
			arm_time      = '0;
			fall_count    = '0;
			tap_open      = 1'b0;
			armed         = 1'b0;
			will_confirm  = 1'b0;
			alarm_on      = 1'b0;
			owed_outcomes.delete();
			results_taken = 0;
			fault_count   = 0;
			outcomes_owed = 0;
		end else begin
			if (cfg_wen) begin
				case (reg_index_t'(cfg_index))
					REG_PAIR_WINDOW:    pair_win    = cfg_wdata;
					REG_CONFIRM_WINDOW: confirm_win = cfg_wdata;
					REG_FALL_WINDOW:    fall_win    = cfg_wdata;
					REG_FALL_LIMIT:     fall_limit  = cfg_wdata[LIMIT_WIDTH-1:0];
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				got = {result.alarm_active, result.alarm_started, result.alarm_stopped,
					result.find_phone, result.feedback_pulse, result.fall_reports};
				results_taken++;
				if (owed_outcomes.size() == 0) begin
					fault_count++;
					if (fault_count <= 10)
						$display("result %0d arrived with none owed: %s", results_taken,
							describe(got));
				end else begin
					want  = owed_outcomes.pop_front();
					wrong = "";
					if (got.alarm_active !== want.alarm_active)     wrong = {wrong, " alarm_active"};
					if (got.alarm_started !== want.alarm_started)   wrong = {wrong, " alarm_started"};
					if (got.alarm_stopped !== want.alarm_stopped)   wrong = {wrong, " alarm_stopped"};
					if (got.find_phone !== want.find_phone)         wrong = {wrong, " find_phone"};
					if (got.feedback_pulse !== want.feedback_pulse) wrong = {wrong, " feedback_pulse"};
					if (got.fall_reports !== want.fall_reports)     wrong = {wrong, " fall_reports"};
					if (wrong != "") begin
						fault_count++;
						if (fault_count <= 10)
							$display("result %0d wrong in%s: expected %s, got %s", results_taken,
								wrong, describe(want), describe(got));
					end
				end
			end
			if (sensor.valid && sensor.ready)
				owed_outcomes.push_back(judge_event(cmd_t'(sensor.command), sensor.now_ms));
			outcomes_owed = owed_outcomes.size();
		end
	end

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// Tap gesture and fall alarm qualifier: testbench top
// Drives a directed run over window edges, backwards stamps and alarm
// corner cases, then random gestures, fall bursts and noise under several
// window settings with random stalls on both channels; the checker beside
// the block decides each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import tgfa_pkg::*;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_wen;
	logic [CFG_IDX_WIDTH-1:0]  cfg_index;
	logic [CFG_DATA_WIDTH-1:0] cfg_wdata;
	int                        fault_count;
	int                        outcomes_owed;

	logic [TIME_WIDTH-1:0]     uptime;
	logic [WIN_WIDTH-1:0]      pair_w;
	logic [WIN_WIDTH-1:0]      confirm_w;
	logic [WIN_WIDTH-1:0]      fall_w;
	logic [LIMIT_WIDTH-1:0]    limit_w;
	int                        events_sent;
	int                        tx_mood_left;
	bit                        tx_relaxed;
	bit                        calm;
	bit                        hold_off_req;

	tgfa_in_if  sensor_ch ();
	tgfa_out_if result_ch ();

	tap_gesture_and_fall_alarm_qualifier u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.sensor    (sensor_ch),
		.result    (result_ch),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	tgfa_qualifier_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.sensor        (sensor_ch),
		.result        (result_ch),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.fault_count   (fault_count),
		.outcomes_owed (outcomes_owed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : result_side
		int stall_left;
		int mood_left;
		bit relaxed;
		stall_left = 0;
		mood_left  = 0;
		relaxed    = 1'b0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (mood_left == 0) begin
				relaxed   = ($urandom_range(0, 3) == 0);
				mood_left = $urandom_range(16, 64);
			end
			mood_left--;
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_left   = 40;
			end
			if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else if (!calm && !relaxed && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 2);
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// call at a rising edge; returns at the edge that takes the request
	task automatic send_event(input cmd_t cmd, input logic [TIME_WIDTH-1:0] stamp);
		if (tx_mood_left == 0) begin
			tx_relaxed   = ($urandom_range(0, 3) == 0);
			tx_mood_left = $urandom_range(8, 40);
		end
		tx_mood_left--;
		if (!calm && !tx_relaxed && $urandom_range(0, 4) == 0) begin
			sensor_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		sensor_ch.valid   <= 1'b1;
		sensor_ch.command <= cmd;
		sensor_ch.now_ms  <= stamp;
		@(negedge clk);
		while (!sensor_ch.ready) @(negedge clk);
		@(posedge clk);
		events_sent++;
	endtask

	task automatic drain();
		sensor_ch.valid <= 1'b0;
		while (outcomes_owed != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_regs(
		input logic [WIN_WIDTH-1:0]      pair,
		input logic [WIN_WIDTH-1:0]      confirm,
		input logic [WIN_WIDTH-1:0]      fall,
		input logic [CFG_DATA_WIDTH-1:0] limit_word
	);
		cfg_wen   <= 1'b1;
		cfg_index <= REG_PAIR_WINDOW;
		cfg_wdata <= pair;
		@(posedge clk);
		cfg_index <= REG_CONFIRM_WINDOW;
		cfg_wdata <= confirm;
		@(posedge clk);
		cfg_index <= REG_FALL_WINDOW;
		cfg_wdata <= fall;
		@(posedge clk);
		cfg_index <= REG_FALL_LIMIT;
		cfg_wdata <= limit_word;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		pair_w    = pair;
		confirm_w = confirm;
		fall_w    = fall;
		limit_w   = limit_word[LIMIT_WIDTH-1:0];
	endtask

	// mostly inside the window, now and then past it by up to one more window
	function automatic logic [TIME_WIDTH-1:0] hop(input logic [WIN_WIDTH-1:0] win);
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 7)
			return TIME_WIDTH'($urandom_range(0, win));
		else if (pick < 9)
			return TIME_WIDTH'(win) + 40'd1 + TIME_WIDTH'($urandom_range(0, win));
		return '0;
	endfunction

	task automatic random_traffic(input int count);
		int target;
		int pick;
		int n;
		target = events_sent + count;
		while (events_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				uptime += hop(confirm_w);
				send_event(CMD_DOUBLE_TAP, uptime);
				uptime += hop(pair_w);
				send_event(CMD_DOUBLE_TAP, uptime);
			end else if (pick < 60) begin
				if ($urandom_range(0, 3) == 0)
					n = $urandom_range(1, int'(limit_w) + 1);
				else
					n = int'(limit_w) + 1 + $urandom_range(0, 2);
				uptime += TIME_WIDTH'(fall_w) + 40'd1;
				repeat (n) begin
					if ($urandom_range(0, 7) == 0)
						uptime += hop(fall_w);
					else
						uptime += TIME_WIDTH'($urandom_range(0, int'(fall_w) / n));
					send_event(CMD_FREE_FALL, uptime);
				end
			end else if (pick < 70) begin
				uptime += TIME_WIDTH'($urandom_range(0, 3000));
				send_event(CMD_PEER_CLEAR, uptime);
			end else if (pick < 78) begin
				uptime += TIME_WIDTH'($urandom_range(0, 3000));
				send_event(CMD_IGNORED, uptime);
			end else if (pick < 94) begin
				uptime += TIME_WIDTH'($urandom_range(0, 70000));
				send_event(cmd_t'($urandom_range(0, 3)), uptime);
			end else begin
				if ($urandom_range(0, 1) == 0)
					uptime = TIME_WIDTH'({$urandom, $urandom});
				else
					uptime -= TIME_WIDTH'($urandom_range(0, 3000));
				send_event(cmd_t'($urandom_range(0, 3)), uptime);
			end
		end
	endtask

	initial begin : stimulus
		int i;
		arst_n            <= 1'b0;
		cfg_wen           <= 1'b0;
		cfg_index         <= REG_PAIR_WINDOW;
		cfg_wdata         <= '0;
		sensor_ch.valid   <= 1'b0;
		sensor_ch.command <= CMD_IGNORED;
		sensor_ch.now_ms  <= '0;
		pair_w       = PAIR_WINDOW_RST;
		confirm_w    = CONFIRM_WINDOW_RST;
		fall_w       = FALL_WINDOW_RST;
		limit_w      = FALL_LIMIT_RST;
		uptime       = '0;
		events_sent  = 0;
		tx_mood_left = 0;
		tx_relaxed   = 1'b0;
		calm         = 1'b0;
		hold_off_req = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_event(CMD_IGNORED, 40'd0);
		send_event(CMD_PEER_CLEAR, 40'd10);
		send_event(CMD_DOUBLE_TAP, 40'd100);
		send_event(CMD_DOUBLE_TAP, 40'd2100);
		send_event(CMD_DOUBLE_TAP, 40'd3000);
		send_event(CMD_DOUBLE_TAP, 40'd3500);
		for (i = 0; i < 5; i++)
			send_event(CMD_FREE_FALL, 40'd4000 + TIME_WIDTH'(i * 250));
		for (i = 0; i < 5; i++)
			send_event(CMD_FREE_FALL, 40'd5100 + TIME_WIDTH'(i * 100));
		send_event(CMD_DOUBLE_TAP, 40'd5600);
		send_event(CMD_DOUBLE_TAP, 40'd5000);
		send_event(CMD_FREE_FALL, 40'd20000);
		send_event(CMD_DOUBLE_TAP, '1);
		send_event(CMD_DOUBLE_TAP, '1);
		send_event(CMD_FREE_FALL, '0);
		send_event(CMD_FREE_FALL, '0);
		uptime = '0;
		drain();

		// lower the limit with a count still open
		write_regs(16'd300, 16'd1500, 16'd400, 16'd1);
		send_event(CMD_FREE_FALL, uptime);
		random_traffic(40);
		hold_off_req = 1'b1;
		random_traffic(45);
		drain();

		write_regs('0, '0, '0, '0);
		random_traffic(40);
		drain();
		random_traffic(45);
		drain();

		write_regs('1, '1, '1, '1);
		random_traffic(85);
		drain();

		write_regs(WIN_WIDTH'($urandom_range(0, 4000)), WIN_WIDTH'($urandom_range(0, 8000)),
			WIN_WIDTH'($urandom_range(0, 3000)), CFG_DATA_WIDTH'($urandom_range(0, 65535)));
		random_traffic(85);
		drain();

		calm = 1'b1;
		write_regs(PAIR_WINDOW_RST, CONFIRM_WINDOW_RST, FALL_WINDOW_RST,
			CFG_DATA_WIDTH'(FALL_LIMIT_RST));
		random_traffic(85);
		drain();

		repeat (20) @(posedge clk);
		if (fault_count == 0 && outcomes_owed == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ tap_gesture_and_fall_alarm_qualifier.f @@
+incdir+rtl/core
rtl/core/tgfa_pkg.sv
rtl/core/tgfa_in_if.sv
rtl/core/tgfa_out_if.sv
rtl/core/tgfa_qual.sv
rtl/core/tap_gesture_and_fall_alarm_qualifier.sv
rtl/core/tgfa_checker.sv
test/tgfa_qualifier_checker.sv
test/tb.sv
